// ===== hdl/vpts_pkg.sv =====
// Shared types, constants and saturation helper for the vertex projection block.
// No dependencies.
package vpts_pkg;

    localparam int WORD_W        = 32;
    localparam int DEF_FRAC_BITS = 16;
    localparam int VP_W          = 14;
    localparam int WIDE_W        = 66;

    localparam logic [VP_W-1:0] RESET_WIDTH  = 14'd640;
    localparam logic [VP_W-1:0] RESET_HEIGHT = 14'd480;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] val;
        logic                     flag;
    } sat_t;

    // clamp a wide signed value to 32 bits
    function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        r.val  = v[WORD_W-1:0];
        r.flag = 1'b0;
        if ((v[WIDE_W-1:WORD_W-1] != '0) && (v[WIDE_W-1:WORD_W-1] != '1)) begin
            r.flag = 1'b1;
            r.val  = v[WIDE_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== hdl/vpts_matvec.sv =====
// Two-stage 4x4 matrix by vector multiply: products, then floored row sums with clamp.
// Depends on vpts_pkg.
module vpts_matvec #(
    parameter int FRAC_BITS = vpts_pkg::DEF_FRAC_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic          in_sat,
    input  vpts_pkg::word_t mat_i [16],
    input  vpts_pkg::word_t vec_i [4],
    output logic          out_valid,
    output logic          out_sat,
    output vpts_pkg::word_t vec_o [4]
);
    logic signed [63:0] prod_reg [16];
    logic               valid_a_reg;
    logic               sat_a_reg;
    logic               valid_b_reg;
    logic               sat_b_reg;
    vpts_pkg::word_t    vec_reg [4];
    vpts_pkg::word_t    vec_next [4];
    logic               sat_next;

    always_comb begin
        logic signed [vpts_pkg::WIDE_W-1:0] acc;
        vpts_pkg::sat_t                     s;
        sat_next = sat_a_reg;
        for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int c = 0; c < 4; c++) begin
                acc = acc + vpts_pkg::WIDE_W'(prod_reg[r*4+c] >>> FRAC_BITS);
            end
            s           = vpts_pkg::sat32(acc);
            vec_next[r] = s.val;
            sat_next    = sat_next | s.flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    prod_reg[r*4+c] <= $signed(mat_i[r*4+c]) * $signed(vec_i[c]);
                end
            end
            sat_a_reg <= in_sat;
            vec_reg   <= vec_next;
            sat_b_reg <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (adv) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_sat   = sat_b_reg;
    assign vec_o     = vec_reg;

endmodule

// ===== hdl/vpts_div.sv =====
// Pipelined restoring divider for the perspective divide, one quotient bit per stage.
// Depends on vpts_pkg.
module vpts_div #(
    parameter int FRAC_BITS = vpts_pkg::DEF_FRAC_BITS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  logic            in_sat,
    input  vpts_pkg::word_t clip_i [4],
    output logic            out_valid,
    output logic            out_sat,
    output logic            out_wz,
    output vpts_pkg::word_t ndc_x,
    output vpts_pkg::word_t ndc_y
);
    localparam int QW = vpts_pkg::WORD_W + FRAC_BITS;
    localparam int W  = vpts_pkg::WORD_W;

    logic          valid_reg [QW+1];
    logic          wz_reg    [QW+1];
    logic          sat_reg   [QW+1];
    logic          negx_reg  [QW+1];
    logic          negy_reg  [QW+1];
    logic [W-1:0]  dv_reg    [QW+1];
    logic [W-1:0]  rx_reg    [QW+1];
    logic [W-1:0]  ry_reg    [QW+1];
    logic [QW-1:0] shx_reg   [QW+1];
    logic [QW-1:0] shy_reg   [QW+1];

    logic [W-1:0] ax, ay, aw;
    logic         wz;

    logic            fvalid_reg;
    logic            fsat_reg;
    logic            fwz_reg;
    vpts_pkg::word_t fx_reg;
    vpts_pkg::word_t fy_reg;
    vpts_pkg::sat_t  qx_sat, qy_sat;

    assign wz = (clip_i[3] == '0);
    assign ax = clip_i[0][W-1] ? W'(-clip_i[0]) : clip_i[0];
    assign ay = clip_i[1][W-1] ? W'(-clip_i[1]) : clip_i[1];
    assign aw = wz ? W'(1) : (clip_i[3][W-1] ? W'(-clip_i[3]) : clip_i[3]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            wz_reg[0]   <= wz;
            sat_reg[0]  <= in_sat;
            negx_reg[0] <= clip_i[0][W-1] ^ clip_i[3][W-1];
            negy_reg[0] <= clip_i[1][W-1] ^ clip_i[3][W-1];
            dv_reg[0]   <= aw;
            rx_reg[0]   <= '0;
            ry_reg[0]   <= '0;
            shx_reg[0]  <= {ax, {FRAC_BITS{1'b0}}};
            shy_reg[0]  <= {ay, {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= in_valid;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [W:0] tx, ty;
        logic       gex, gey;

        assign tx  = {rx_reg[k], shx_reg[k][QW-1]};
        assign ty  = {ry_reg[k], shy_reg[k][QW-1]};
        assign gex = (tx >= {1'b0, dv_reg[k]});
        assign gey = (ty >= {1'b0, dv_reg[k]});

        always_ff @(posedge aclk) begin
            if (adv) begin
                wz_reg[k+1]   <= wz_reg[k];
                sat_reg[k+1]  <= sat_reg[k];
                negx_reg[k+1] <= negx_reg[k];
                negy_reg[k+1] <= negy_reg[k];
                dv_reg[k+1]   <= dv_reg[k];
                rx_reg[k+1]   <= gex ? W'(tx - {1'b0, dv_reg[k]}) : tx[W-1:0];
                ry_reg[k+1]   <= gey ? W'(ty - {1'b0, dv_reg[k]}) : ty[W-1:0];
                shx_reg[k+1]  <= {shx_reg[k][QW-2:0], gex};
                shy_reg[k+1]  <= {shy_reg[k][QW-2:0], gey};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_comb begin
        logic signed [vpts_pkg::WIDE_W-1:0] qx, qy;
        qx = $signed({{(vpts_pkg::WIDE_W-QW){1'b0}}, shx_reg[QW]});
        qy = $signed({{(vpts_pkg::WIDE_W-QW){1'b0}}, shy_reg[QW]});
        qx_sat = vpts_pkg::sat32(negx_reg[QW] ? -qx : qx);
        qy_sat = vpts_pkg::sat32(negy_reg[QW] ? -qy : qy);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fwz_reg  <= wz_reg[QW];
            fsat_reg <= sat_reg[QW] | (!wz_reg[QW] & (qx_sat.flag | qy_sat.flag));
            fx_reg   <= qx_sat.val;
            fy_reg   <= qy_sat.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvalid_reg <= 1'b0;
        end else if (adv) begin
            fvalid_reg <= valid_reg[QW];
        end
    end

    assign out_valid = fvalid_reg;
    assign out_sat   = fsat_reg;
    assign out_wz    = fwz_reg;
    assign ndc_x     = fx_reg;
    assign ndc_y     = fy_reg;

endmodule

// ===== hdl/vpts_viewport.sv =====
// Viewport mapping in two stages: scale by width and height, then halve and clamp.
// Depends on vpts_pkg.
module vpts_viewport #(
    parameter int FRAC_BITS = vpts_pkg::DEF_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic                      in_sat,
    input  logic                      in_wz,
    input  vpts_pkg::word_t           ndc_x,
    input  vpts_pkg::word_t           ndc_y,
    input  logic [vpts_pkg::VP_W-1:0] width,
    input  logic [vpts_pkg::VP_W-1:0] height,
    output logic                      out_valid,
    output logic                      out_sat,
    output logic                      out_wz,
    output vpts_pkg::word_t           scr_x,
    output vpts_pkg::word_t           scr_y
);
    localparam int W  = vpts_pkg::WORD_W;
    localparam int PW = W + 1 + vpts_pkg::VP_W + 1;
    localparam logic signed [W:0] ONE = (W+1)'(1) <<< FRAC_BITS;

    logic signed [W:0]    hx, hy;
    logic signed [PW-1:0] tx_reg, ty_reg;
    logic                 valid_a_reg, sat_a_reg, wz_a_reg;
    logic                 valid_b_reg, sat_b_reg, wz_b_reg;
    vpts_pkg::word_t      x_reg, y_reg;
    vpts_pkg::sat_t       sx, sy;

    assign hx = $signed({ndc_x[W-1], ndc_x}) + ONE;
    assign hy = ONE - $signed({ndc_y[W-1], ndc_y});
    assign sx = vpts_pkg::sat32(vpts_pkg::WIDE_W'(tx_reg >>> 1));
    assign sy = vpts_pkg::sat32(vpts_pkg::WIDE_W'(ty_reg >>> 1));

    always_ff @(posedge aclk) begin
        if (adv) begin
            tx_reg    <= hx * $signed({1'b0, width});
            ty_reg    <= hy * $signed({1'b0, height});
            sat_a_reg <= in_sat;
            wz_a_reg  <= in_wz;
            wz_b_reg  <= wz_a_reg;
            sat_b_reg <= sat_a_reg | (!wz_a_reg & (sx.flag | sy.flag));
            x_reg     <= wz_a_reg ? '0 : sx.val;
            y_reg     <= wz_a_reg ? '0 : sy.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (adv) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_sat   = sat_b_reg;
    assign out_wz    = wz_b_reg;
    assign scr_x     = x_reg;
    assign scr_y     = y_reg;

endmodule

// ===== hdl/vertex_project_to_screen_top.sv =====
// Vertex projection top level: matrix store, two matrix stages, divider, viewport.
// Depends on vpts_pkg, vpts_matvec, vpts_div and vpts_viewport.
//
// Takes one request per clock while the output is not stalled and returns one result
// per point request, in order; numbers are Q16.16 at the default FRAC_BITS. The
// bit-per-stage divider sets most of the pipeline depth. Load requests write a
// coefficient at once and give no result; load only while no points are in flight.
// The whole pipeline holds while a result waits at the output.
module vertex_project_to_screen_top #(
    parameter int FRAC_BITS = vpts_pkg::DEF_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // coef_index, coef_value, point_x, point_y, point_z, zero pad
    input  logic [135:0]              s_tdata,
    // cmd
    input  logic [0:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // screen_x, screen_y
    output logic [63:0]               m_tdata,
    // w_was_zero, saturated
    output logic [1:0]                m_tuser,
    input  logic                      cfg_wr_en,
    input  logic [0:0]                cfg_addr,
    input  logic [vpts_pkg::VP_W-1:0] cfg_wdata
);
    localparam int W = vpts_pkg::WORD_W;
    localparam vpts_pkg::word_t ONE = W'(1) <<< FRAC_BITS;

    logic                      adv, accept;
    vpts_pkg::word_t           mv_reg [16];
    vpts_pkg::word_t           pj_reg [16];
    logic [vpts_pkg::VP_W-1:0] width_reg, height_reg;
    logic                      p_valid_reg;
    vpts_pkg::word_t           p_reg [4];
    logic [4:0]                cidx;

    logic            eye_valid, eye_sat, clip_valid, clip_sat;
    vpts_pkg::word_t eye [4];
    vpts_pkg::word_t clip [4];
    logic            d_valid, d_sat, d_wz;
    vpts_pkg::word_t nx, ny;
    logic            o_sat, o_wz;
    vpts_pkg::word_t sx, sy;

    assign adv    = !m_tvalid || m_tready;
    assign accept = s_tvalid && adv;
    assign cidx   = s_tdata[4:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                mv_reg[i] <= (i % 5 == 0) ? ONE : '0;
                pj_reg[i] <= (i % 5 == 0) ? ONE : '0;
            end
            width_reg  <= vpts_pkg::RESET_WIDTH;
            height_reg <= vpts_pkg::RESET_HEIGHT;
        end else begin
            if (accept && s_tuser[0] == vpts_pkg::CMD_LOAD) begin
                if (cidx[4]) begin
                    pj_reg[cidx[3:0]] <= s_tdata[36:5];
                end else begin
                    mv_reg[cidx[3:0]] <= s_tdata[36:5];
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr[0])
                    vpts_pkg::REG_WIDTH:  width_reg  <= cfg_wdata;
                    vpts_pkg::REG_HEIGHT: height_reg <= cfg_wdata;
                    default:              width_reg  <= width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (adv) begin
            p_valid_reg <= s_tvalid && (s_tuser[0] == vpts_pkg::CMD_POINT);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[0] <= s_tdata[68:37];
            p_reg[1] <= s_tdata[100:69];
            p_reg[2] <= s_tdata[132:101];
            p_reg[3] <= ONE;
        end
    end

    vpts_matvec #(.FRAC_BITS(FRAC_BITS)) u_modelview (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(p_valid_reg), .in_sat(1'b0), .mat_i(mv_reg), .vec_i(p_reg),
        .out_valid(eye_valid), .out_sat(eye_sat), .vec_o(eye)
    );

    vpts_matvec #(.FRAC_BITS(FRAC_BITS)) u_projection (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(eye_valid), .in_sat(eye_sat), .mat_i(pj_reg), .vec_i(eye),
        .out_valid(clip_valid), .out_sat(clip_sat), .vec_o(clip)
    );

    vpts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(clip_valid), .in_sat(clip_sat), .clip_i(clip),
        .out_valid(d_valid), .out_sat(d_sat), .out_wz(d_wz), .ndc_x(nx), .ndc_y(ny)
    );

    vpts_viewport #(.FRAC_BITS(FRAC_BITS)) u_viewport (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(d_valid), .in_sat(d_sat), .in_wz(d_wz), .ndc_x(nx), .ndc_y(ny),
        .width(width_reg), .height(height_reg),
        .out_valid(m_tvalid), .out_sat(o_sat), .out_wz(o_wz), .scr_x(sx), .scr_y(sy)
    );

    assign s_tready = adv;
    assign m_tdata  = {sy, sx};
    assign m_tuser  = {o_sat, o_wz};

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");

    a_zero_w_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero w result not at origin");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == vpts_pkg::CMD_LOAD |=> !p_valid_reg)
        else $error("load request entered the pipeline");

endmodule
